// ===== rtl/sorted_leaf_block_table_macros.svh =====
// Assertion helpers
`ifndef SORTED_LEAF_BLOCK_TABLE_MACROS_SVH
`define SORTED_LEAF_BLOCK_TABLE_MACROS_SVH
`define SLBT_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m: lbl");
`define SLBT_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("%m: lbl");
`endif

// ===== rtl/slbt_pkg.sv =====
package slbt_pkg;
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_LOOKUP  = 2'd1;
  localparam logic [1:0] REQ_SCAN    = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REFUSED  = 3'd1;
  localparam logic [2:0] ST_MOVED    = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_SCAN     = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [63:0] value;
    logic        allow_split;
    logic [6:0]  scan_count;
  } req_t;
endpackage

// ===== rtl/slbt_front.sv =====
module slbt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  slbt_pkg::req_t req_i,
  input  logic           take_i,
  output logic           full_o,
  output slbt_pkg::req_t req_o
);
  import slbt_pkg::*;
  logic full_q, full_d;
  req_t req_q;

  always_comb begin
    full_d = full_q;
    if (take_i) full_d = 1'b0;
    if (start_i && !full_q && req_i.req_type != REQ_UNKNOWN) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else full_q <= full_d;
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !full_q) req_q <= req_i;
  end

  assign full_o = full_q;
  assign req_o  = req_q;
endmodule

// ===== rtl/slbt_engine.sv =====
module slbt_engine #(
  parameter int CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  slbt_pkg::req_t req_i,
  output logic           take_o,
  output logic           res_valid_o,
  output logic [2:0]     status_o,
  output logic [63:0]    out_key_o,
  output logic [63:0]    out_value_o,
  output logic           last_o,
  output logic [6:0]     taken_o
);
  import slbt_pkg::*;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = 8;
  localparam logic [CW-1:0] CAP  = CW'(CAPACITY);
  localparam logic [CW-1:0] HALF = CW'(CAPACITY / 2);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_MOVE  = 3'd6;

  logic [63:0] kmem [CAPACITY];
  logic [63:0] vmem [CAPACITY];

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, end_q, end_d, pos_q, pos_d;
  logic          spl_q, spl_d, kept_q, kept_d, ins_q, ins_d;
  req_t          r_q, r_d;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [63:0]   wk, wv, rk_q, rv_q;
  logic [CW-1:0] scan_rem, scan_want, scan_take;
  logic          ov_q, ov_d, ol_q, ol_d;
  logic [2:0]    os_q, os_d;
  logic [63:0]   ok_q, ok_d, ovl_q, ovl_d;
  logic [6:0]    ot_q, ot_d;

  // Memory with registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      kmem[waddr] <= wk;
      vmem[waddr] <= wv;
    end
    rk_q <= kmem[raddr];
    rv_q <= vmem[raddr];
  end

  assign scan_rem  = cnt_q - i_q;
  assign scan_want = CW'(r_q.scan_count);
  assign scan_take = (scan_want < scan_rem) ? scan_want : scan_rem;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; end_d = end_q; pos_d = pos_q;
    spl_d = spl_q; kept_d = kept_q; ins_d = ins_q; r_d = r_q;
    raddr = i_q[AW-1:0];
    we = 1'b0; waddr = i_q[AW-1:0]; wk = rk_q; wv = rv_q;
    ov_d = 1'b0; os_d = os_q; ok_d = '0; ovl_d = '0; ol_d = 1'b0; ot_d = '0;
    take_o = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (req_valid_i) begin
          take_o = 1'b1;
          r_d = req_i;
          i_d = '0;
          spl_d = 1'b0;
          raddr = '0;
          if (req_i.req_type == REQ_INSERT && cnt_q >= CAP) begin
            if (!req_i.allow_split) begin
              ov_d = 1'b1; os_d = ST_REFUSED; ol_d = 1'b1;
            end else begin
              // compare with last kept key first
              raddr = AW'(HALF - ONE);
              st_d = S_CMP;
            end
          end else begin
            st_d = S_SRCH;
          end
        end
      end
      S_CMP: begin
        spl_d = 1'b1;
        kept_d = (r_q.key <= rk_q);
        ins_d = (r_q.key <= rk_q);
        i_d = HALF;
        raddr = AW'(HALF);
        st_d = S_MOVE;
      end
      S_SRCH: begin
        // rk_q holds the entry at i_q
        if (i_q >= cnt_q || rk_q >= r_q.key) begin
          pos_d = i_q;
          unique case (r_q.req_type)
            REQ_INSERT: begin
              if (i_q == cnt_q) begin
                st_d = S_PUT;
              end else begin
                i_d = cnt_q;
                raddr = AW'(cnt_q - ONE);
                st_d = S_SHIFT;
              end
            end
            REQ_LOOKUP: begin
              ov_d = 1'b1; ol_d = 1'b1; st_d = S_IDLE;
              if (i_q < cnt_q && rk_q == r_q.key) begin
                os_d = ST_HIT; ok_d = rk_q; ovl_d = rv_q;
              end else begin
                os_d = ST_MISS;
              end
            end
            default: begin
              if (scan_take == '0) begin
                ov_d = 1'b1; ol_d = 1'b1; os_d = ST_EMPTY;
                st_d = S_IDLE;
              end else begin
                end_d = i_q + scan_take;
                st_d = S_EMIT;
              end
            end
          endcase
        end else begin
          i_d = i_q + ONE;
          raddr = AW'(i_q + ONE);
        end
      end
      S_SHIFT: begin
        // move entry i-1 to i, i descending to pos
        we = 1'b1;
        i_d = i_q - ONE;
        if (i_q - ONE == pos_q) st_d = S_PUT;
        else raddr = AW'(i_q - TWO);
      end
      S_PUT: begin
        we = 1'b1; waddr = pos_q[AW-1:0]; wk = r_q.key; wv = r_q.value;
        cnt_d = cnt_q + ONE;
        st_d = S_IDLE;
        if (!spl_q) begin
          ov_d = 1'b1; os_d = ST_INSERTED; ol_d = 1'b1;
        end
      end
      S_EMIT: begin
        ov_d = 1'b1; os_d = ST_SCAN; ok_d = rk_q; ovl_d = rv_q;
        i_d = i_q + ONE;
        raddr = AW'(i_q + ONE);
        if (i_q + ONE == end_q) begin
          ol_d = 1'b1; ot_d = 7'(end_q - pos_q); st_d = S_IDLE;
        end
      end
      S_MOVE: begin
        // upper half out in key order, new pair merged in when it belongs there
        ov_d = 1'b1; os_d = ST_MOVED;
        if (!ins_q && (i_q == CAP || rk_q >= r_q.key)) begin
          ok_d = r_q.key; ovl_d = r_q.value; ins_d = 1'b1;
          if (i_q == CAP) begin
            ol_d = 1'b1; cnt_d = HALF; st_d = S_IDLE;
          end
        end else begin
          ok_d = rk_q; ovl_d = rv_q;
          i_d = i_q + ONE;
          raddr = AW'(i_q + ONE);
          if (i_q + ONE == CAP && ins_q) begin
            ol_d = 1'b1; cnt_d = HALF;
            if (kept_q) begin
              i_d = '0; raddr = '0; st_d = S_SRCH;
            end else begin
              st_d = S_IDLE;
            end
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; ov_q <= 1'b0; ol_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d; ol_q <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; end_q <= end_d; pos_q <= pos_d; r_q <= r_d;
    spl_q <= spl_d; kept_q <= kept_d; ins_q <= ins_d;
    os_q <= os_d; ok_q <= ok_d; ovl_q <= ovl_d; ot_q <= ot_d;
  end

  assign res_valid_o = ov_q;
  assign status_o    = os_q;
  assign out_key_o   = ok_q;
  assign out_value_o = ovl_q;
  assign last_o      = ol_q;
  assign taken_o     = ot_q;

  `include "sorted_leaf_block_table_macros.svh"
  `SLBT_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, cnt_q <= CAP)
  `SLBT_ASSERT_NEXT(a_take_idle, clk_i, rst_ni, take_o, st_q != S_IDLE || ov_q)
  `SLBT_ASSERT_IMPL(a_last_valid, clk_i, rst_ni, !ol_q || ov_q)
endmodule

// ===== rtl/sorted_leaf_block_table.sv =====
// A lookup or scan first searches linearly for the lower-bound position; an insert searches
// likewise, shifts the entries above it up, then writes the pair; a split compares, then moves.
// The engine holds one transaction at a time;
// a one-entry slot accepts the next transaction while the engine runs.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the table; no clearing pass is run.
module sorted_leaf_block_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] req_key_i,
  input  logic [63:0] req_value_i,
  input  logic        allow_split_i,
  input  logic [6:0]  scan_count_i,
  output logic        res_valid_o,
  output logic [2:0]  status_o,
  output logic [63:0] out_key_o,
  output logic [63:0] out_value_o,
  output logic        last_o,
  output logic [6:0]  taken_o
);
  import slbt_pkg::*;
  req_t req_in, req_f;
  logic full, take;

  assign req_in = '{req_type: req_type_i, key: req_key_i, value: req_value_i,
                    allow_split: allow_split_i, scan_count: scan_count_i};

  slbt_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i(req_in), .take_i(take),
    .full_o(full), .req_o(req_f)
  );

  slbt_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk_i, .rst_ni, .req_valid_i(full), .req_i(req_f), .take_o(take),
    .res_valid_o, .status_o, .out_key_o, .out_value_o, .last_o, .taken_o
  );

  assign busy = full;
endmodule
